// ===== src/diff_drive_wheel_pwm_controller_top_macros.svh =====
// Assertion helpers for the drive controller
`ifndef DIFF_DRIVE_WHEEL_PWM_CONTROLLER_TOP_MACROS_SVH
`define DIFF_DRIVE_WHEEL_PWM_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ddw_pkg.sv =====
package ddw_pkg;

	// field widths
	localparam int RPM_W   = 20;
	localparam int DRV_W   = 24;
	localparam int PWM_W   = 11;
	localparam int DIV_N   = 32;
	localparam int DIV_CW  = 6;
	localparam int DVS_W   = 17;

	localparam logic signed [RPM_W-1:0] RPM_MAX = {1'b0, {(RPM_W-1){1'b1}}};
	localparam logic signed [RPM_W-1:0] RPM_MIN = {1'b1, {(RPM_W-1){1'b0}}};
	localparam logic signed [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic signed [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

	// wheel speed scaling: v = lin*2000 -+ ang*base, rpm_q4 = v*12 / (25*circ)
	localparam logic signed [26:0] LIN_SCALE = 27'sd2000;
	localparam logic [DVS_W-1:0]   CIRC_SCALE = 17'd25;

	// configuration register indexes
	localparam logic [2:0] REG_WHEEL_BASE  = 3'd0;
	localparam logic [2:0] REG_CIRCUMF     = 3'd1;
	localparam logic [2:0] REG_GAIN        = 3'd2;
	localparam logic [2:0] REG_DAMPING     = 3'd3;
	localparam logic [2:0] REG_MIN_KICK    = 3'd4;
	localparam logic [2:0] REG_PWM_LIMIT   = 3'd5;
	localparam logic [2:0] REG_LIN_THRESH  = 3'd6;
	localparam logic [2:0] REG_SPIN_THRESH = 3'd7;

	// operations issued to a wheel lane
	typedef enum logic [3:0] {
		LOP_NONE,
		LOP_CLEAR,
		LOP_MUL,
		LOP_DIV,
		LOP_WB,
		LOP_KICK,
		LOP_FCLR,
		LOP_FMUL,
		LOP_ACC
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     fwd;
		logic     kick_en;
	} lane_ctl_t;

	typedef struct packed {
		logic div_busy;
	} lane_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD_MUL,
		ST_CMD_START,
		ST_CMD_DIV,
		ST_CMD_WB,
		ST_FB_MUL,
		ST_FB_ACC,
		ST_FB_OUT
	} ctl_state_t;

endpackage

// ===== src/ddw_div.sv =====
module ddw_div
	import ddw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_N-1:0]  dividend,
	input  logic [DVS_W-1:0]  divisor,
	output logic              busy,
	output logic [DIV_N-1:0]  quotient
);

	logic [DVS_W-1:0]  rem_q;
	logic [DIV_N-1:0]  quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic [DVS_W:0]    rem_sh;
	logic              ge;
	logic [DVS_W-1:0]  rem_nxt;

	// one restoring step: shift in the next dividend bit, try subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_N-1]};
		ge      = rem_sh >= {1'b0, divisor};
		rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CW'(DIV_N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_N-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== src/ddw_lane.sv =====
module ddw_lane
	import ddw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic                    is_right,
	input  logic signed [15:0]      lin_mm_s,
	input  logic signed [15:0]      ang_mrad_s,
	input  logic signed [11:0]      meas_rpm,
	input  logic [11:0]             wheel_base_mm,
	input  logic [11:0]             circumference_mm,
	input  logic [9:0]              gain_q8,
	input  logic [8:0]              damping_q8,
	input  logic [9:0]              min_kick_pwm,
	input  logic [9:0]              pwm_limit,
	output lane_sts_t               sts,
	output logic signed [PWM_W-1:0] pwm
);

	function automatic logic signed [RPM_W-1:0] sat_rpm(input logic signed [RPM_W:0] v);
		sat_rpm = (v[RPM_W] != v[RPM_W-1]) ? (v[RPM_W] ? RPM_MIN : RPM_MAX) : v[RPM_W-1:0];
	endfunction

	function automatic logic signed [DRV_W-1:0] sat_drv(input logic signed [28:0] v);
		if (v[28]) begin
			sat_drv = (&v[27:DRV_W-1]) ? v[DRV_W-1:0] : DRV_MIN;
		end else begin
			sat_drv = (|v[27:DRV_W-1]) ? DRV_MAX : v[DRV_W-1:0];
		end
	endfunction

	// wheel state
	logic signed [RPM_W-1:0] target_q;
	logic signed [RPM_W-1:0] err_q;
	logic signed [11:0]      meas_q;
	logic signed [DRV_W-1:0] drive_q;

	// pipeline payload
	logic signed [26:0] lin_k_s1;
	logic signed [27:0] ang_b_s1;
	logic               neg_s2;
	logic [18:0]        gd_s1;
	logic signed [39:0] prod_s2;

	logic signed [28:0]      v;
	logic signed [32:0]      v12;
	logic [DIV_N-1:0]        v_mag;
	logic [11:0]             circ_eff;
	logic [DVS_W-1:0]        dvs;
	logic                    div_busy;
	logic [DIV_N-1:0]        quo;
	logic signed [RPM_W-1:0] rq;
	logic signed [RPM_W-1:0] rq_neg;
	logic signed [RPM_W-1:0] tgt;
	logic signed [RPM_W:0]   m16;
	logic signed [RPM_W:0]   e21;
	logic [DRV_W-1:0]        dmag;
	logic [DRV_W-1:0]        kick;
	logic signed [DRV_W-1:0] kick_drv;
	logic signed [39:0]      padj;
	logic signed [27:0]      step;
	logic signed [28:0]      dsum;
	logic signed [DRV_W-1:0] dadj;
	logic signed [15:0]      p;
	logic signed [15:0]      lims;

	// wheel linear speed, scaled by 12 and split into sign and magnitude
	always_comb begin
		v        = is_right ? (29'(lin_k_s1) + 29'(ang_b_s1)) : (29'(lin_k_s1) - 29'(ang_b_s1));
		v12      = (33'(v) <<< 3) + (33'(v) <<< 2);
		v_mag    = v12[32] ? DIV_N'(-v12) : v12[DIV_N-1:0];
		circ_eff = (circumference_mm == 12'd0) ? 12'd1 : circumference_mm;
		dvs      = DVS_W'(circ_eff) * CIRC_SCALE;
	end

	ddw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.op == LOP_DIV),
		.dividend (v_mag),
		.divisor  (dvs),
		.busy     (div_busy),
		.quotient (quo)
	);

	// signed rpm target and error from the quotient
	always_comb begin
		if (neg_s2) begin
			rq = ((|quo[DIV_N-1:RPM_W]) || (quo[RPM_W-1] && (|quo[RPM_W-2:0]))) ? RPM_MIN
				: RPM_W'(-$signed({1'b0, quo[RPM_W-1:0]}));
		end else begin
			rq = (|quo[DIV_N-1:RPM_W-1]) ? RPM_MAX : $signed({1'b0, quo[RPM_W-2:0]});
		end
		rq_neg = (rq == RPM_MIN) ? RPM_MAX : -rq;
		tgt    = (is_right ? ctl.fwd : !ctl.fwd) ? rq_neg : rq;
		m16    = $signed({{5{meas_q[11]}}, meas_q, 4'b0000});
		e21    = ctl.fwd ? (21'(tgt) - m16) : (21'(tgt) + m16);
	end

	// kick and drive accumulation
	always_comb begin
		dmag     = drive_q[DRV_W-1] ? DRV_W'(-drive_q) : drive_q;
		kick     = {6'b0, min_kick_pwm, 8'b0};
		kick_drv = ((target_q < 0) != !ctl.fwd) ? DRV_W'(-$signed(kick)) : $signed(kick);
		padj     = prod_s2 + (prod_s2[39] ? 40'sd4095 : 40'sd0);
		step     = padj[39:12];
		dsum     = ctl.fwd ? (29'(drive_q) + 29'(step)) : (29'(drive_q) - 29'(step));
	end

	// pwm: truncate toward zero, clamp
	always_comb begin
		dadj = drive_q + (drive_q[DRV_W-1] ? 24'sd255 : 24'sd0);
		p    = dadj[DRV_W-1:8];
		lims = $signed({6'b0, pwm_limit});
		if (p > lims) begin
			pwm = PWM_W'(lims);
		end else if (p < -lims) begin
			pwm = PWM_W'(-lims);
		end else begin
			pwm = PWM_W'(p);
		end
	end

	// wheel state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			err_q    <= '0;
			meas_q   <= '0;
			drive_q  <= '0;
		end else begin
			unique case (ctl.op)
				LOP_CLEAR: begin
					target_q <= '0;
					err_q    <= '0;
					drive_q  <= '0;
				end
				LOP_FCLR: begin
					meas_q   <= meas_rpm;
					target_q <= '0;
					err_q    <= '0;
					drive_q  <= '0;
				end
				LOP_WB: begin
					target_q <= tgt;
					err_q    <= sat_rpm(e21);
				end
				LOP_KICK: begin
					meas_q <= meas_rpm;
					if (ctl.kick_en && (dmag < kick)) begin
						drive_q <= kick_drv;
					end
				end
				LOP_ACC: begin
					drive_q <= sat_drv(dsum);
				end
				default: begin
				end
			endcase
		end
	end

	// multiplier stages
	always_ff @(posedge clk) begin
		if (ctl.op == LOP_MUL) begin
			lin_k_s1 <= 27'(lin_mm_s) * LIN_SCALE;
			ang_b_s1 <= 28'(ang_mrad_s) * 28'($signed({1'b0, wheel_base_mm}));
		end
		if (ctl.op == LOP_DIV) begin
			neg_s2 <= v12[32];
		end
		if (ctl.op == LOP_KICK) begin
			gd_s1 <= 19'(gain_q8) * 19'(damping_q8);
		end
		if (ctl.op == LOP_FMUL) begin
			prod_s2 <= 40'($signed({1'b0, gd_s1})) * 40'(err_q);
		end
	end

	assign sts.div_busy = div_busy;

endmodule

// ===== src/diff_drive_wheel_pwm_controller_top.sv =====
// Two-wheel drive controller. A command item (tuser 0) stores linear and turn
// speed and, outside the spin and deadband cases, derives per-wheel target rpm
// and error; it gives no result and waits on the 32-step restoring divider in
// each wheel lane (a spin or deadband command is handled as it is accepted).
// A feedback item (tuser 1) latches the measured rpm, updates the drive levels
// and returns one PWM pair via the multiply, accumulate and output states (only
// the output state when stopped). Items are taken one at a time; a finished PWM
// pair waits in the output register while the next items are accepted.
module diff_drive_wheel_pwm_controller_top
	import ddw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // linear_mm_s, angular_mrad_s, speed_left_rpm, speed_right_rpm
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // left drive, right drive, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	// configuration
	logic [11:0] wheel_base_q;
	logic [11:0] circ_q;
	logic [9:0]  gain_q;
	logic [8:0]  damping_q;
	logic [9:0]  min_kick_q;
	logic [9:0]  pwm_limit_q;
	logic [14:0] lin_thresh_q;
	logic [14:0] spin_thresh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q  <= 12'd530;
			circ_q        <= 12'd534;
			gain_q        <= 10'd26;
			damping_q     <= 9'd230;
			min_kick_q    <= 10'd45;
			pwm_limit_q   <= 10'd500;
			lin_thresh_q  <= 15'd10;
			spin_thresh_q <= 15'd2900;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WHEEL_BASE:  wheel_base_q  <= cfg_data[11:0];
				REG_CIRCUMF:     circ_q        <= cfg_data[11:0];
				REG_GAIN:        gain_q        <= cfg_data[9:0];
				REG_DAMPING:     damping_q     <= cfg_data[8:0];
				REG_MIN_KICK:    min_kick_q    <= cfg_data[9:0];
				REG_PWM_LIMIT:   pwm_limit_q   <= cfg_data[9:0];
				REG_LIN_THRESH:  lin_thresh_q  <= cfg_data;
				REG_SPIN_THRESH: spin_thresh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// request fields
	logic               req_acc;
	logic signed [15:0] in_lin;
	logic signed [15:0] in_ang;
	logic signed [11:0] in_sl;
	logic signed [11:0] in_sr;

	assign in_lin = s_tdata[15:0];
	assign in_ang = s_tdata[31:16];
	assign in_sl  = s_tdata[43:32];
	assign in_sr  = s_tdata[55:44];

	// stored command
	logic signed [15:0] cmd_lin_q;
	logic signed [15:0] cmd_ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_lin_q <= '0;
			cmd_ang_q <= '0;
		end else if (req_acc && !s_tuser) begin
			cmd_lin_q <= in_lin;
			cmd_ang_q <= in_ang;
		end
	end

	// speed classification
	logic signed [16:0] thr_s;
	logic signed [16:0] spin_s;
	logic signed [16:0] cl17;
	logic signed [16:0] ca_mag;
	logic signed [16:0] nl17;
	logic signed [16:0] nl_mag;
	logic signed [16:0] na17;
	logic signed [16:0] na_mag;
	logic               moving;
	logic               fwd;
	logic               spin_ok;
	logic               new_spin;
	logic               new_slow;

	always_comb begin
		thr_s    = $signed({2'b00, lin_thresh_q});
		spin_s   = $signed({2'b00, spin_thresh_q});
		cl17     = 17'(cmd_lin_q);
		ca_mag   = cmd_ang_q[15] ? -17'(cmd_ang_q) : 17'(cmd_ang_q);
		nl17     = 17'(in_lin);
		nl_mag   = in_lin[15] ? -nl17 : nl17;
		na17     = 17'(in_ang);
		na_mag   = in_ang[15] ? -na17 : na17;
		fwd      = cl17 > thr_s;
		moving   = fwd || (cl17 < -thr_s);
		spin_ok  = ca_mag < spin_s;
		new_spin = na_mag > spin_s;
		new_slow = nl_mag <= thr_s;
	end

	// sequencer
	ctl_state_t state_q;
	ctl_state_t state_d;
	lane_ctl_t  lane_ctl;
	lane_sts_t  sts_l;
	lane_sts_t  sts_r;
	logic       out_free;
	logic       out_load;
	logic       m_tvalid_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign req_acc  = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser) begin
						state_d = moving ? ST_FB_MUL : ST_FB_OUT;
					end else if (!new_spin && !new_slow) begin
						state_d = ST_CMD_MUL;
					end
				end
			end
			ST_CMD_MUL:   state_d = ST_CMD_START;
			ST_CMD_START: state_d = ST_CMD_DIV;
			ST_CMD_DIV: begin
				if (!sts_l.div_busy && !sts_r.div_busy) begin
					state_d = ST_CMD_WB;
				end
			end
			ST_CMD_WB:    state_d = ST_IDLE;
			ST_FB_MUL:    state_d = ST_FB_ACC;
			ST_FB_ACC:    state_d = ST_FB_OUT;
			ST_FB_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		out_load         = 1'b0;
		lane_ctl.op      = LOP_NONE;
		lane_ctl.fwd     = fwd;
		lane_ctl.kick_en = spin_ok;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						lane_ctl.op = moving ? LOP_KICK : LOP_FCLR;
					end else if (!new_spin && new_slow) begin
						lane_ctl.op = LOP_CLEAR;
					end
				end
			end
			ST_CMD_MUL:   lane_ctl.op = LOP_MUL;
			ST_CMD_START: lane_ctl.op = LOP_DIV;
			ST_CMD_WB:    lane_ctl.op = LOP_WB;
			ST_FB_MUL:    lane_ctl.op = LOP_FMUL;
			ST_FB_ACC:    lane_ctl.op = LOP_ACC;
			ST_FB_OUT:    out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// wheel lanes
	logic signed [PWM_W-1:0] pwm_l;
	logic signed [PWM_W-1:0] pwm_r;

	ddw_lane u_lane_l (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (lane_ctl),
		.is_right         (1'b0),
		.lin_mm_s         (cmd_lin_q),
		.ang_mrad_s       (cmd_ang_q),
		.meas_rpm         (in_sl),
		.wheel_base_mm    (wheel_base_q),
		.circumference_mm (circ_q),
		.gain_q8          (gain_q),
		.damping_q8       (damping_q),
		.min_kick_pwm     (min_kick_q),
		.pwm_limit        (pwm_limit_q),
		.sts              (sts_l),
		.pwm              (pwm_l)
	);

	ddw_lane u_lane_r (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (lane_ctl),
		.is_right         (1'b1),
		.lin_mm_s         (cmd_lin_q),
		.ang_mrad_s       (cmd_ang_q),
		.meas_rpm         (in_sr),
		.wheel_base_mm    (wheel_base_q),
		.circumference_mm (circ_q),
		.gain_q8          (gain_q),
		.damping_q8       (damping_q),
		.min_kick_pwm     (min_kick_q),
		.pwm_limit        (pwm_limit_q),
		.sts              (sts_r),
		.pwm              (pwm_r)
	);

	// merged output register
	logic signed [PWM_W-1:0] out_left_q;
	logic signed [PWM_W-1:0] out_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= pwm_l;
			out_right_q <= pwm_r;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_right_q, out_left_q};

	// checks
	logic signed [11:0] lim_s;
	logic               pwm_in_lim;
	assign lim_s      = $signed({2'b00, pwm_limit_q});
	assign pwm_in_lim = (12'(out_left_q) <= lim_s) && (12'(out_left_q) >= -lim_s)
		&& (12'(out_right_q) <= lim_s) && (12'(out_right_q) >= -lim_s);

`include "diff_drive_wheel_pwm_controller_top_macros.svh"

	`ASSERT_SAME(a_wb_after_div, state_q == ST_CMD_WB, !sts_l.div_busy && !sts_r.div_busy, "target written while divider busy")
	`ASSERT_NEXT(a_out_loaded, out_load, m_tvalid && (state_q == ST_IDLE), "pwm pair not presented")
	`ASSERT_SAME(a_pwm_clamp, m_tvalid, pwm_in_lim, "pwm outside limit")

endmodule
